// ===== rtl/vgl_pkg.sv =====
package vgl_pkg;

  // Grid geometry: GRID_SIZE cells per side, one memory row per (x, y) pair
  // holding all z cells of that column.
  localparam int GRID_SIZE = 64;
  localparam int AXIS_W    = $clog2(GRID_SIZE);
  localparam int ROW_W     = GRID_SIZE;
  localparam int ROWS      = GRID_SIZE * GRID_SIZE;
  localparam int ADDR_W    = $clog2(ROWS);

  // Field widths fixed by the stream format.
  localparam int COORD_W = 6;
  localparam int NBR_W   = COORD_W + 2;
  localparam int CNT_W   = 7;
  localparam int ERR_W   = COORD_W + 3;
  localparam int THR_W   = 8;

  localparam logic [THR_W-1:0] THR_RESET = 8'd7;

  // Opcodes carried on in_tuser.
  localparam logic [1:0] OP_MARK  = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_TRACE = 2'd2;

  // Line classes.
  localparam logic [1:0] CLS_INSIDE  = 2'd0;
  localparam logic [1:0] CLS_OUTSIDE = 2'd1;
  localparam logic [1:0] CLS_MIXED   = 2'd2;

  typedef logic [COORD_W-1:0] coord_t;

  // One voxel probe issued by the line walker.
  typedef struct packed {
    logic   valid;
    logic   last;
    coord_t x;
    coord_t y;
    coord_t z;
  } walk_probe_t;

  // True when a possibly negative neighbor coordinate lies inside the grid.
  function automatic logic nbr_in_grid(input logic [NBR_W-1:0] v);
    return !v[NBR_W-1] && (int'(v) < GRID_SIZE);
  endfunction

  // Memory row of an (x, y) column.
  function automatic logic [ADDR_W-1:0] row_addr(input logic [NBR_W-1:0] x,
                                                 input logic [NBR_W-1:0] y);
    return ADDR_W'(int'(x) * GRID_SIZE + int'(y));
  endfunction

endpackage

// ===== rtl/voxel_grid_line_occupancy_trace.sv =====
// Mark and clear: paint steps over the neighbor columns, then tally and finish.
// Trace: walker setup, n = max(span, 1) <= 63 probes, tally and finish; the line
// walker reads one occupancy row from the grid memory per cycle.
// Unused opcode: straight to finish. Items are taken only in idle, once the prior
// result is loaded. After rst_n the grid memory is swept clear, one row a cycle,
// all ROWS (4096) rows, while in_tready stays low; outside_threshold resets to 7.
module voxel_grid_line_occupancy_trace (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel. tuser: opcode[1:0].
  // tdata: start_x[5:0], start_y[11:6], start_z[17:12], end_x[23:18],
  //        end_y[29:24], end_z[35:30], zero pad[39:36].
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,
  input  logic [39:0] in_tdata,
  // Result channel. tdata: line_class[1:0], occupied_count[8:2],
  //                        visited_count[15:9].
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  // Configuration: outside_threshold.
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);
  import vgl_pkg::*;

  typedef enum logic [5:0] {
    ST_INIT   = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_PAINT  = 6'b000100,
    ST_TRACE  = 6'b001000,
    ST_TALLY  = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t             state_r, state_nxt;
  logic [ADDR_W-1:0]  clr_addr_r;
  logic [1:0]         op_r;
  coord_t             cx_r, cy_r, cz_r;
  logic [1:0]         da_r, db_r;
  logic               wr_pend_r;
  logic [ADDR_W-1:0]  wr_addr_r;
  logic               rd_pend_r;
  logic [AXIS_W-1:0]  rd_z_r;
  logic [CNT_W-1:0]   visited_r, occupied_r;
  logic [THR_W-1:0]   thr_r;
  logic               out_valid_r;
  logic [15:0]        out_data_r;

  logic               in_accept;
  logic               out_load;
  logic               walk_start;
  walk_probe_t        probe;
  logic [NBR_W-1:0]   nx, ny;
  logic               paint_issue, probe_ok;
  logic [ROW_W-1:0]   mask;
  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [ROW_W-1:0]   ram_wdata, ram_rdata;
  logic [1:0]         cls;
  logic [CNT_W:0]     occ_plus;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_accept  = in_tvalid && in_tready;
  assign walk_start = in_accept && (in_tuser == OP_TRACE);
  assign out_load   = (state_r == ST_FINISH) && (!out_valid_r || out_tready);

  vgl_walker u_walker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (walk_start),
    .start_x (in_tdata[5:0]),
    .start_y (in_tdata[11:6]),
    .start_z (in_tdata[17:12]),
    .end_x   (in_tdata[23:18]),
    .end_y   (in_tdata[29:24]),
    .end_z   (in_tdata[35:30]),
    .probe   (probe)
  );

  // Neighbor column of the current paint step and the z mask of the 3x3x3 cube.
  always_comb begin
    logic [NBR_W-1:0] nz;
    nx   = {2'b00, cx_r} + {{(NBR_W-2){1'b0}}, da_r} - NBR_W'(1);
    ny   = {2'b00, cy_r} + {{(NBR_W-2){1'b0}}, db_r} - NBR_W'(1);
    mask = '0;
    for (int c = 0; c < 3; c++) begin
      nz = {2'b00, cz_r} + NBR_W'(c) - NBR_W'(1);
      if (nbr_in_grid(nz)) begin
        mask[AXIS_W'(nz)] = 1'b1;
      end
    end
  end

  assign paint_issue = (state_r == ST_PAINT) && nbr_in_grid(nx) && nbr_in_grid(ny);
  assign probe_ok    = probe.valid && nbr_in_grid({2'b00, probe.x}) &&
                       nbr_in_grid({2'b00, probe.y}) && nbr_in_grid({2'b00, probe.z});

  // Grid memory ports: clearing sweep or paint write-back, paint or probe read.
  always_comb begin
    ram_re    = paint_issue || probe_ok;
    ram_raddr = (state_r == ST_PAINT) ? row_addr(nx, ny)
                                      : row_addr({2'b00, probe.x}, {2'b00, probe.y});
    if (state_r == ST_INIT) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = wr_pend_r;
      ram_waddr = wr_addr_r;
      ram_wdata = (op_r == OP_MARK) ? (ram_rdata | mask) : (ram_rdata & ~mask);
    end
  end

  vgl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS)
  ) u_grid (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Line class from the two counts.
  always_comb begin
    occ_plus = {1'b0, occupied_r} + (CNT_W+1)'(1);
    if (op_r != OP_TRACE) begin
      cls = CLS_INSIDE;
    end else if (occ_plus >= {1'b0, visited_r}) begin
      cls = CLS_INSIDE;
    end else if ({1'b0, occupied_r} <= thr_r) begin
      cls = CLS_OUTSIDE;
    end else begin
      cls = CLS_MIXED;
    end
  end

  // Control sequence.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: begin
        if (clr_addr_r == ADDR_W'(ROWS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_accept) begin
          if (in_tuser == OP_MARK || in_tuser == OP_CLEAR) begin
            state_nxt = ST_PAINT;
          end else if (in_tuser == OP_TRACE) begin
            state_nxt = ST_TRACE;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_PAINT: begin
        if (da_r == 2'd2 && db_r == 2'd2) state_nxt = ST_TALLY;
      end
      ST_TRACE: begin
        if (probe.valid && probe.last) state_nxt = ST_TALLY;
      end
      ST_TALLY:  state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      clr_addr_r  <= '0;
      wr_pend_r   <= 1'b0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      thr_r       <= THR_RESET;
    end else begin
      state_r   <= state_nxt;
      wr_pend_r <= paint_issue;
      rd_pend_r <= probe_ok;
      if (state_r == ST_INIT) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
    end
  end

  // Item registers, paint step counters and trace counts.
  always_ff @(posedge clk) begin
    wr_addr_r <= ram_raddr;
    rd_z_r    <= AXIS_W'(probe.z);
    if (in_accept) begin
      op_r       <= in_tuser;
      cx_r       <= in_tdata[5:0];
      cy_r       <= in_tdata[11:6];
      cz_r       <= in_tdata[17:12];
      da_r       <= 2'd0;
      db_r       <= 2'd0;
      visited_r  <= '0;
      occupied_r <= '0;
    end else begin
      if (state_r == ST_PAINT) begin
        if (db_r == 2'd2) begin
          db_r <= 2'd0;
          da_r <= da_r + 2'd1;
        end else begin
          db_r <= db_r + 2'd1;
        end
      end
      if (probe.valid) begin
        visited_r <= visited_r + CNT_W'(1);
      end
      if (rd_pend_r && ram_rdata[rd_z_r]) begin
        occupied_r <= occupied_r + CNT_W'(1);
      end
    end
    if (out_load) begin
      out_data_r <= (op_r == OP_TRACE) ? {visited_r, occupied_r, cls} : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  // Trace reads never share a cycle with a grid write.
  a_no_write_during_probe: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !probe.valid)
    else $error("grid write during a line probe");

  // The walker probes only while the top level is tracing.
  a_probe_in_trace: assert property (@(posedge clk) disable iff (!rst_n)
    probe.valid |-> (state_r == ST_TRACE))
    else $error("line probe outside of a trace");

  // Occupied voxels never outnumber visited voxels.
  a_occ_le_visit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH) |-> (occupied_r <= visited_r))
    else $error("occupied count exceeds visited count");

  // A result appears only after the finish step.
  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("result raised outside of the finish step");
`endif

endmodule

// ===== rtl/vgl_ram.sv =====
module vgl_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/vgl_walker.sv =====
module vgl_walker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  vgl_pkg::coord_t      start_x,
  input  vgl_pkg::coord_t      start_y,
  input  vgl_pkg::coord_t      start_z,
  input  vgl_pkg::coord_t      end_x,
  input  vgl_pkg::coord_t      end_y,
  input  vgl_pkg::coord_t      end_z,
  output vgl_pkg::walk_probe_t probe
);
  import vgl_pkg::*;

  typedef enum logic [2:0] {
    W_IDLE  = 3'b001,
    W_SETUP = 3'b010,
    W_RUN   = 3'b100
  } walk_state_t;

  walk_state_t             state_r, state_nxt;
  coord_t                  pos_r [3];
  coord_t                  dst_r [3];
  logic                    neg_r [3];
  logic [COORD_W-1:0]      span_r [3];
  logic signed [ERR_W-1:0] err_r [3];
  logic [1:0]              major_r;
  logic [COORD_W-1:0]      len_r;
  logic [CNT_W-1:0]        remain_r;

  logic [COORD_W:0]        diff [3];
  logic                    neg_nxt [3];
  logic [COORD_W-1:0]      span_nxt [3];
  logic [1:0]              major_nxt;
  logic [COORD_W-1:0]      len_nxt;
  logic signed [ERR_W-1:0] err_init [3];
  logic signed [ERR_W-1:0] err_step [3];
  coord_t                  pos_step [3];
  logic signed [ERR_W-1:0] two_len;
  logic signed [ERR_W-1:0] two_span [3];

  // Setup: per-axis direction and span, dominant axis and initial error terms.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k]     = {1'b0, dst_r[k]} - {1'b0, pos_r[k]};
      neg_nxt[k]  = diff[k][COORD_W];
      span_nxt[k] = neg_nxt[k] ? COORD_W'(-diff[k]) : diff[k][COORD_W-1:0];
    end
    if (span_nxt[0] >= span_nxt[1] && span_nxt[0] >= span_nxt[2]) begin
      major_nxt = 2'd0;
    end else if (span_nxt[1] >= span_nxt[0] && span_nxt[1] >= span_nxt[2]) begin
      major_nxt = 2'd1;
    end else begin
      major_nxt = 2'd2;
    end
    len_nxt = span_nxt[major_nxt];
    for (int k = 0; k < 3; k++) begin
      err_init[k] = $signed({2'b00, span_nxt[k], 1'b0}) - $signed({3'b000, len_nxt});
    end
  end

  // One Bresenham step: the dominant axis always advances, minor axes on error.
  always_comb begin
    two_len = $signed({2'b00, len_r, 1'b0});
    for (int k = 0; k < 3; k++) begin
      two_span[k] = $signed({2'b00, span_r[k], 1'b0});
      pos_step[k] = pos_r[k];
      err_step[k] = err_r[k];
      if (2'(k) == major_r) begin
        pos_step[k] = neg_r[k] ? pos_r[k] - COORD_W'(1) : pos_r[k] + COORD_W'(1);
      end else if (err_r[k] > 0) begin
        pos_step[k] = neg_r[k] ? pos_r[k] - COORD_W'(1) : pos_r[k] + COORD_W'(1);
        err_step[k] = err_r[k] - two_len + two_span[k];
      end else begin
        err_step[k] = err_r[k] + two_span[k];
      end
    end
  end

  // Sequencer: idle, a setup state, then one probe per cycle.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      W_IDLE:  if (start) state_nxt = W_SETUP;
      W_SETUP: state_nxt = W_RUN;
      W_RUN:   if (remain_r == CNT_W'(1)) state_nxt = W_IDLE;
      default: state_nxt = W_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= W_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Walk registers.
  always_ff @(posedge clk) begin
    if (state_r == W_IDLE && start) begin
      pos_r[0] <= start_x;
      pos_r[1] <= start_y;
      pos_r[2] <= start_z;
      dst_r[0] <= end_x;
      dst_r[1] <= end_y;
      dst_r[2] <= end_z;
    end else if (state_r == W_SETUP) begin
      neg_r    <= neg_nxt;
      span_r   <= span_nxt;
      err_r    <= err_init;
      major_r  <= major_nxt;
      len_r    <= len_nxt;
      remain_r <= (len_nxt == '0) ? CNT_W'(1) : {1'b0, len_nxt};
    end else if (state_r == W_RUN) begin
      pos_r    <= pos_step;
      err_r    <= err_step;
      remain_r <= remain_r - CNT_W'(1);
    end
  end

  assign probe.valid = (state_r == W_RUN);
  assign probe.last  = (remain_r == CNT_W'(1));
  assign probe.x     = pos_r[0];
  assign probe.y     = pos_r[1];
  assign probe.z     = pos_r[2];

endmodule

// ===== bench/voxel_trace_checker.sv =====
module voxel_trace_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [1:0]  in_tuser,
  input  logic [39:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  output int          mismatches,
  output int          results_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import vgl_pkg::*;

  localparam int GRID_CELLS = GRID_SIZE * GRID_SIZE * GRID_SIZE;

  typedef struct packed {
    logic [1:0]       line_class;
    logic [CNT_W-1:0] occupied;
    logic [CNT_W-1:0] visited;
  } line_result_t;

  // Shadow copy of the occupancy grid and the outside threshold.
  bit               occupancy [GRID_CELLS];
  logic [THR_W-1:0] outside_limit;
  line_result_t     pending_line_results [$];
  int               reported;

  function automatic bit in_bounds(int x, int y, int z);
    return x >= 0 && y >= 0 && z >= 0 && x < GRID_SIZE && y < GRID_SIZE && z < GRID_SIZE;
  endfunction

  function automatic bit cell_at(int x, int y, int z);
    if (!in_bounds(x, y, z)) begin
      return 1'b0;
    end
    return occupancy[(x * GRID_SIZE + y) * GRID_SIZE + z];
  endfunction

  // Set or clear the 3x3x3 block around a voxel, skipping cells off the grid.
  function automatic void paint_block(int cx, int cy, int cz, bit value);
    int x, y, z;
    for (int a = -1; a <= 1; a++) begin
      for (int b = -1; b <= 1; b++) begin
        for (int c = -1; c <= 1; c++) begin
          x = cx + a;
          y = cy + b;
          z = cz + c;
          if (in_bounds(x, y, z)) begin
            occupancy[(x * GRID_SIZE + y) * GRID_SIZE + z] = value;
          end
        end
      end
    end
  endfunction

  // Walk the line along its dominant axis; the end voxel is not visited unless it is the start voxel.
  function automatic line_result_t trace_line(coord_t sx, coord_t sy, coord_t sz,
                                              coord_t ex, coord_t ey, coord_t ez);
    int pos [3];
    int dst [3];
    int dir [3];
    int span [3];
    int err [3];
    int major, len, occ, vis;
    line_result_t r;
    pos[0] = sx;
    pos[1] = sy;
    pos[2] = sz;
    dst[0] = ex;
    dst[1] = ey;
    dst[2] = ez;
    for (int k = 0; k < 3; k++) begin
      dir[k]  = (dst[k] < pos[k]) ? -1 : 1;
      span[k] = (dst[k] < pos[k]) ? pos[k] - dst[k] : dst[k] - pos[k];
    end
    // Ties go to x first, then y.
    if (span[0] >= span[1] && span[0] >= span[2]) begin
      major = 0;
    end else if (span[1] >= span[2]) begin
      major = 1;
    end else begin
      major = 2;
    end
    len = span[major];
    for (int k = 0; k < 3; k++) begin
      err[k] = 2 * span[k] - len;
    end
    occ = 0;
    vis = 0;
    for (int i = 1; i < len; i++) begin
      vis++;
      occ += cell_at(pos[0], pos[1], pos[2]);
      for (int k = 0; k < 3; k++) begin
        if (k != major) begin
          if (err[k] > 0) begin
            pos[k] += dir[k];
            err[k] -= 2 * len;
          end
          err[k] += 2 * span[k];
        end
      end
      pos[major] += dir[major];
    end
    vis++;
    occ += cell_at(pos[0], pos[1], pos[2]);
    if (occ + 1 >= vis) begin
      r.line_class = CLS_INSIDE;
    end else if (occ <= int'(outside_limit)) begin
      r.line_class = CLS_OUTSIDE;
    end else begin
      r.line_class = CLS_MIXED;
    end
    r.occupied = CNT_W'(occ);
    r.visited  = CNT_W'(vis);
    return r;
  endfunction

  // Apply one accepted transaction to the shadow state and return its result.
  function automatic line_result_t apply_item(logic [1:0] op, logic [39:0] data);
    line_result_t r;
    coord_t sx, sy, sz, ex, ey, ez;
    sx = data[5:0];
    sy = data[11:6];
    sz = data[17:12];
    ex = data[23:18];
    ey = data[29:24];
    ez = data[35:30];
    r = '0;
    case (op)
      OP_MARK: begin
        paint_block(sx, sy, sz, 1'b1);
      end
      OP_CLEAR: begin
        paint_block(sx, sy, sz, 1'b0);
      end
      OP_TRACE: begin
        r = trace_line(sx, sy, sz, ex, ey, ez);
      end
      default: begin
        // The spare opcode leaves the grid alone and answers with zeros.
      end
    endcase
    return r;
  endfunction

  function automatic void log_error(string what, int want, int got);
    mismatches++;
    if (reported < 10) begin
      reported++;
      $display("[%0t] result error: %s expected %0d, got %0d", $realtime, what, want, got);
    end
  endfunction

  // Results are checked before new transactions are predicted, since a result
  // never belongs to an item taken at the same edge.
  always @(posedge clk) begin
    line_result_t got, want;
    if (!rst_n) begin
      occupancy = '{default: 1'b0};
      outside_limit = THR_RESET;
      pending_line_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.line_class = out_tdata[1:0];
        got.occupied   = out_tdata[8:2];
        got.visited    = out_tdata[15:9];
        if (pending_line_results.size() == 0) begin
          log_error("result with none outstanding, tdata", 0, int'(out_tdata));
        end else begin
          want = pending_line_results.pop_front();
          if (got.line_class !== want.line_class) begin
            log_error("line_class", want.line_class, got.line_class);
          end
          if (got.occupied !== want.occupied) begin
            log_error("occupied_count", want.occupied, got.occupied);
          end
          if (got.visited !== want.visited) begin
            log_error("visited_count", want.visited, got.visited);
          end
        end
      end
      if (cfg_wr_en) begin
        outside_limit = cfg_wr_data;
      end
      if (in_tvalid && in_tready) begin
        pending_line_results.insert(pending_line_results.size(),
                                    apply_item(in_tuser, in_tdata));
      end
    end
    results_pending = pending_line_results.size();
  end

endmodule

// ===== bench/voxel_grid_line_occupancy_trace_tb.sv =====
module voxel_grid_line_occupancy_trace_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vgl_pkg::*;

  localparam logic [1:0] OP_SPARE      = 2'd3;
  localparam int         PHASES        = 5;
  localparam int         PHASE_ITEMS   = 300;
  localparam int         WATCHDOG_IDLE = 20000;
  localparam int         TAIL_CYCLES   = 100;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [1:0]  in_tuser;   // opcode[1:0]
  logic [39:0] in_tdata;   // start_x, start_y, start_z, end_x, end_y, end_z, zero pad
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // line_class, occupied_count, visited_count
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;

  int error_count;
  int pending_results;
  int send_quiet;
  int recv_quiet;
  int center [3];

  voxel_grid_line_occupancy_trace u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  voxel_trace_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tuser       (in_tuser),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .mismatches     (error_count),
    .results_pending(pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap before the next transaction; quiet runs give back-to-back stretches.
  function automatic int draw_gap(inout int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) begin
      quiet_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  // Coordinates lean toward a focus region so traces cross painted cells.
  function automatic coord_t pick_coord(int focus);
    int v;
    case ($urandom_range(0, 9))
      0: v = 0;
      1: v = GRID_SIZE - 1;
      2, 3, 4, 5: v = $urandom_range(0, GRID_SIZE - 1);
      default: v = focus + int'($urandom_range(0, 16)) - 8;
    endcase
    if (v < 0) begin
      v = 0;
    end else if (v > GRID_SIZE - 1) begin
      v = GRID_SIZE - 1;
    end
    return coord_t'(v);
  endfunction

  // Any coordinate, for fields the block ignores.
  function automatic coord_t any_coord();
    return coord_t'($urandom);
  endfunction

  task automatic send_item(input logic [1:0] op, input coord_t sx, input coord_t sy,
                           input coord_t sz, input coord_t ex, input coord_t ey,
                           input coord_t ez);
    int gap;
    gap = draw_gap(send_quiet);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser  = op;
    in_tdata  = {4'b0, ez, ey, ex, sz, sy, sx};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [7:0] value);
    wait_drained();
    repeat (4) @(negedge clk);
    cfg_wr_data = value;
    cfg_wr_en   = 1'b1;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic send_random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      send_item(OP_MARK, pick_coord(center[0]), pick_coord(center[1]),
                pick_coord(center[2]), any_coord(), any_coord(), any_coord());
    end else if (pick < 45) begin
      send_item(OP_CLEAR, pick_coord(center[0]), pick_coord(center[1]),
                pick_coord(center[2]), any_coord(), any_coord(), any_coord());
    end else if (pick < 95) begin
      send_item(OP_TRACE, pick_coord(center[0]), pick_coord(center[1]),
                pick_coord(center[2]), pick_coord(center[0]), pick_coord(center[1]),
                pick_coord(center[2]));
    end else begin
      send_item(OP_SPARE, any_coord(), any_coord(), any_coord(),
                any_coord(), any_coord(), any_coord());
    end
  endtask

  // Result side: random stall before each transaction, ready held until taken.
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = draw_gap(recv_quiet);
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Watchdog on cycles in which no transaction moves on either channel.
  initial begin
    int idle;
    idle = 0;
    while (idle < WATCHDOG_IDLE) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("voxel_grid_line_occupancy_trace: mismatch");
    $finish;
  end

  initial begin
    logic [7:0] limits [PHASES];
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tuser    = '0;
    in_tdata    = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    send_quiet  = 0;
    recv_quiet  = 0;
    limits[0]   = THR_RESET;
    limits[1]   = 8'd0;
    limits[2]   = 8'd255;
    limits[3]   = 8'($urandom_range(1, 254));
    limits[4]   = 8'd20;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty grid, single voxel, full-length and diagonal lines.
    send_item(OP_TRACE, 0, 0, 0, 0, 0, 0);
    send_item(OP_TRACE, 0, 0, 0, 63, 63, 63);
    // Corner marks hang partly off the grid; end fields are ignored.
    send_item(OP_MARK, 0, 0, 0, 63, 63, 63);
    send_item(OP_MARK, 63, 63, 63, 0, 0, 0);
    send_item(OP_TRACE, 63, 63, 63, 0, 0, 0);
    send_item(OP_TRACE, 0, 0, 0, 63, 0, 0);
    // A painted bar along x, then lines through it: mixed and inside.
    for (int i = 5; i <= 17; i += 3) begin
      send_item(OP_MARK, coord_t'(i), 1, 1, 0, 0, 0);
    end
    send_item(OP_TRACE, 0, 1, 1, 40, 1, 1);
    send_item(OP_TRACE, 5, 1, 1, 19, 1, 1);
    send_item(OP_CLEAR, 11, 1, 1, 63, 63, 63);
    send_item(OP_TRACE, 5, 1, 1, 19, 1, 1);
    // Dominant y, dominant z, and the two tie rules.
    send_item(OP_TRACE, 5, 0, 5, 5, 40, 10);
    send_item(OP_TRACE, 1, 2, 0, 3, 4, 63);
    send_item(OP_TRACE, 0, 0, 0, 20, 20, 3);
    send_item(OP_TRACE, 2, 0, 0, 3, 30, 30);
    send_item(OP_SPARE, 63, 63, 63, 63, 63, 63);
    send_item(OP_CLEAR, 0, 63, 0, 0, 0, 0);
    send_item(OP_MARK, 63, 0, 63, 63, 63, 63);
    send_item(OP_TRACE, 63, 63, 63, 63, 63, 63);

    // Random phases, each with its own threshold and a new focus region every 100 items.
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        write_threshold(limits[p]);
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 100 == 0) begin
          for (int k = 0; k < 3; k++) begin
            center[k] = $urandom_range(8, GRID_SIZE - 9);
          end
        end
        if ($urandom_range(0, 199) == 0) begin
          wait_drained();
        end
        send_random_item();
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (error_count == 0 && pending_results == 0) begin
      $display("voxel_grid_line_occupancy_trace: match");
    end else begin
      $display("voxel_grid_line_occupancy_trace: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/vgl_pkg.sv
rtl/vgl_ram.sv
rtl/vgl_walker.sv
rtl/voxel_grid_line_occupancy_trace.sv
bench/voxel_trace_checker.sv
bench/voxel_grid_line_occupancy_trace_tb.sv
